FILE: rtl/tmfb_pkg.sv
// Shared types and constants of the thrust mixer with fuel budget.
// Controller states, mode and register codes, and the command and status
// structs between the controller and the datapath. No dependencies.
`default_nettype none

package tmfb_pkg;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CMD_W     = 8;
	localparam int MAG_W     = 7;
	localparam int SUM_W     = 9;
	localparam int RATE_W    = 12;
	localparam int CAP_W     = 32;
	localparam int SCALE_W   = 10;
	localparam int PCT_W     = 8;
	localparam int PCT_NW    = 40;
	localparam int NPUMP     = 4;

	localparam logic [RATE_W-1:0]  RATE_MAX       = '1;
	localparam logic [MAG_W-1:0]   DEADBAND_RST   = 7'd10;
	localparam logic [MAG_W-1:0]   ROT_THR_RST    = 7'd60;
	localparam logic [CAP_W-1:0]   CAPACITY_RST   = 32'd19980000;
	localparam logic [SCALE_W-1:0] TICK_SCALE_RST = 10'd10;

	typedef enum logic [1:0] {
		MODE_THRUST = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_REMOTE = 2'd2,
		MODE_LOCAL  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND   = 2'd0,
		REG_ROT_THR    = 2'd1,
		REG_CAPACITY   = 2'd2,
		REG_TICK_SCALE = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MIX_SUM,
		ST_PUMP,
		ST_NUM_DIV,
		ST_DUTY_DIV,
		ST_MIX_END,
		ST_TICK_MUL,
		ST_TICK_ADD,
		ST_PCT,
		ST_PCT_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic mix_load;
		logic zero_write;
		logic num_start;
		logic duty_start;
		logic duty_write;
		logic rate_write;
		logic tick_mul;
		logic tick_add;
		logic refuel;
		logic pct_start;
		logic pct_zero;
		logic pct_write;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  empty;
		logic  refuel_flag;
		logic  sum_zero;
		logic  last_pump;
		logic  div_done;
		logic  pct_skip;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tmfb_if.sv
// Valid/ready channels of the thrust mixer: command words in, result words out.
// Stand-alone; the result channel takes the duty width as a parameter.
`default_nettype none

interface tmfb_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic signed [7:0] surge;
	logic signed [7:0] sway;
	logic signed [7:0] yaw;
	logic              refuel_flag;

	modport source(output valid, mode, surge, sway, yaw, refuel_flag, input ready);
	modport sink(input valid, mode, surge, sway, yaw, refuel_flag, output ready);
endinterface

interface tmfb_res_if #(parameter int DUTY_W = 10);
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_front_left;
	logic [DUTY_W-1:0] duty_front_right;
	logic [DUTY_W-1:0] duty_back_right;
	logic [DUTY_W-1:0] duty_back_left;
	logic [7:0]        fuel_percent;
	logic              out_of_fuel;

	modport source(output valid, duty_front_left, duty_front_right, duty_back_right,
		duty_back_left, fuel_percent, out_of_fuel, input ready);
	modport sink(input valid, duty_front_left, duty_front_right, duty_back_right,
		duty_back_left, fuel_percent, out_of_fuel, output ready);
endinterface

`default_nettype wire

FILE: rtl/tmfb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Shared by pump normalization and the fuel percentage.
`default_nettype none

module tmfb_div #(
	parameter int NW = 40,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    dsr_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic             fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[NW-1]};
		fits    = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/tmfb_dp.sv
// Datapath: configuration registers, command capture, axis mixing, pump
// normalization, fuel accounting and the result register. Uses tmfb_pkg, tmfb_div.
`default_nettype none

module tmfb_dp #(
	parameter int PWM_TOP = 999,
	parameter int DUTY_W  = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmfb_pkg::dp_cmd_t                   cmd_c,
	output tmfb_pkg::dp_stat_t                  stat,
	input  logic [1:0]                          in_mode,
	input  logic signed [7:0]                   in_surge,
	input  logic signed [7:0]                   in_sway,
	input  logic signed [7:0]                   in_yaw,
	input  logic                                in_refuel_flag,
	input  logic                                cfg_we,
	input  logic [tmfb_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [tmfb_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                res_ready,
	output logic                                res_valid,
	output logic [DUTY_W-1:0]                   duty_fl,
	output logic [DUTY_W-1:0]                   duty_fr,
	output logic [DUTY_W-1:0]                   duty_br,
	output logic [DUTY_W-1:0]                   duty_bl,
	output logic [tmfb_pkg::PCT_W-1:0]          pct,
	output logic                                empty
);

	import tmfb_pkg::*;

	localparam int SCALE3  = 3 * PWM_TOP;
	localparam int NUM_MAX = 3 * 127 * SCALE3;
	localparam int NUM_W   = $clog2(NUM_MAX + 1);
	localparam int X_W     = NUM_W + 3;
	localparam int DIV_NW  = (X_W > PCT_NW) ? X_W : PCT_NW;
	localparam int PROD_W  = SCALE_W + RATE_W;

	// divide by ten as a reciprocal multiply: ceil(2^23/10), exact below 2^22
	localparam int RECIP_W  = 20;
	localparam int RECIP_SH = 23;
	localparam int DPROD_W  = X_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(838861);

	localparam logic [CAP_W-1:0] DSR_N1  = CAP_W'(127);
	localparam logic [CAP_W-1:0] DSR_N2  = CAP_W'(127 * 2);
	localparam logic [CAP_W-1:0] DSR_N3  = CAP_W'(127 * 2 * 3);
	localparam logic [CAP_W-1:0] DSR_N4  = CAP_W'(127 * 3 * 4);

	function automatic logic [MAG_W-1:0] mag_of(input logic [CMD_W-1:0] raw);
		logic [CMD_W-1:0] neg;
		neg = ~raw + CMD_W'(1);
		if (!raw[CMD_W-1])
			mag_of = raw[MAG_W-1:0];
		else if (neg[CMD_W-1])
			mag_of = '1;
		else
			mag_of = neg[MAG_W-1:0];
	endfunction

	// configuration and architectural state
	logic [MAG_W-1:0]   deadband_q;
	logic [MAG_W-1:0]   rot_thr_q;
	logic [CAP_W-1:0]   capacity_q;
	logic [SCALE_W-1:0] tick_scale_q;
	logic               empty_q;
	logic [CAP_W-1:0]   used_q;
	logic [RATE_W-1:0]  rate_q;
	logic [DUTY_W-1:0]  duty_q [NPUMP];
	logic [1:0]         pump_q;
	logic [RATE_W-1:0]  rate_acc_q;
	logic               out_valid_q;

	// captured command and working registers
	logic [1:0]         mode_q;
	logic [CMD_W-1:0]   surge_q;
	logic [CMD_W-1:0]   sway_q;
	logic [CMD_W-1:0]   yaw_q;
	logic               flag_q;
	logic [SUM_W-1:0]   sum_q [NPUMP];
	logic [2:0]         n_q;
	logic [PROD_W-1:0]  prod_q;
	logic [X_W-1:0]     x_q;
	logic [PCT_W-1:0]   pct_q;
	logic [DUTY_W-1:0]  out_duty_q [NPUMP];
	logic [PCT_W-1:0]   out_pct_q;
	logic               out_empty_q;

	// mixing
	logic [MAG_W-1:0]   mag_s, mag_w, mag_y;
	logic               act_s, act_w, act_y;
	logic [1:0]         k;
	logic [SUM_W-1:0]   share3;
	logic [MAG_W-1:0]   share;
	logic [SUM_W-1:0]   s_fwd, s_aft, w_rgt, w_lft, y_cw, y_ccw;
	logic [SUM_W-1:0]   sum_c [NPUMP];
	logic [2:0]         n_c;

	// normalization and fuel
	logic [SUM_W-1:0]   cur_sum;
	logic [NUM_W-1:0]   num;
	logic [CAP_W-1:0]   dsr_sel;
	logic [NUM_W-1:0]   t;
	logic [X_W-1:0]     x;
	logic [NUM_W:0]     rate_sum;
	logic [DPROD_W-1:0] duty_prod;
	logic [NUM_W-1:0]   duty_quo;
	logic [DUTY_W-1:0]  duty_new;
	logic [CAP_W:0]     used_sum;
	logic [CAP_W-1:0]   used_new;
	logic [CAP_W-1:0]   diff;
	logic [PCT_NW-1:0]  pct_num;

	// divider port
	logic               div_start;
	logic [DIV_NW-1:0]  div_dividend;
	logic [CAP_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIV_NW-1:0]  quo;

	always_comb begin
		mag_s = mag_of(surge_q);
		mag_w = mag_of(sway_q);
		mag_y = mag_of(yaw_q);
		act_s = mag_s > deadband_q;
		act_w = mag_w > deadband_q;
		act_y = mag_y > deadband_q;
		k = {1'b0, act_s && (mag_s >= rot_thr_q)} + {1'b0, act_w && (mag_w >= rot_thr_q)};
		share3 = {2'b00, mag_y} + {1'b0, mag_y, 1'b0};
		unique case (k)
			2'd0:    share = mag_y;
			2'd1:    share = share3[SUM_W-1:2];
			default: share = {1'b0, mag_y[MAG_W-1:1]};
		endcase
		// surge+ feeds the back pair, sway+ the right pair, yaw+ front right/back left
		s_aft = (act_s && !surge_q[CMD_W-1]) ? SUM_W'(mag_s) : '0;
		s_fwd = (act_s &&  surge_q[CMD_W-1]) ? SUM_W'(mag_s) : '0;
		w_rgt = (act_w && !sway_q[CMD_W-1])  ? SUM_W'(mag_w) : '0;
		w_lft = (act_w &&  sway_q[CMD_W-1])  ? SUM_W'(mag_w) : '0;
		y_cw  = (act_y && !yaw_q[CMD_W-1])   ? SUM_W'(share) : '0;
		y_ccw = (act_y &&  yaw_q[CMD_W-1])   ? SUM_W'(share) : '0;
		sum_c[0] = s_fwd + w_lft + y_ccw;
		sum_c[1] = s_fwd + w_rgt + y_cw;
		sum_c[2] = s_aft + w_rgt + y_ccw;
		sum_c[3] = s_aft + w_lft + y_cw;
		n_c = 3'(sum_c[0] != '0) + 3'(sum_c[1] != '0) + 3'(sum_c[2] != '0)
			+ 3'(sum_c[3] != '0);
	end

	always_comb begin
		cur_sum = sum_q[pump_q];
		num     = NUM_W'(cur_sum) * NUM_W'(SCALE3);
		unique case (n_q)
			3'd4:    dsr_sel = DSR_N4;
			3'd3:    dsr_sel = DSR_N3;
			3'd2:    dsr_sel = DSR_N2;
			default: dsr_sel = DSR_N1;
		endcase
		t         = quo[NUM_W-1:0];
		x         = X_W'({t, 3'b000}) - X_W'(t) + X_W'(SCALE3);
		rate_sum  = (NUM_W + 1)'(rate_acc_q) + (NUM_W + 1)'(t);
		duty_prod = DPROD_W'(x_q) * DPROD_W'(RECIP_TEN);
		duty_quo  = duty_prod[DPROD_W-1:RECIP_SH];
		duty_new  = (duty_quo > NUM_W'(PWM_TOP)) ? DUTY_W'(PWM_TOP) : duty_quo[DUTY_W-1:0];
		used_sum  = (CAP_W + 1)'(used_q) + (CAP_W + 1)'(prod_q);
		used_new  = used_sum[CAP_W] ? '1 : used_sum[CAP_W-1:0];
		diff      = capacity_q - used_q;
		pct_num   = {diff, 8'h00} - PCT_NW'(diff);
	end

	always_comb begin
		div_start = cmd_c.num_start || cmd_c.pct_start;
		priority if (cmd_c.num_start) begin
			div_dividend = DIV_NW'(num);
			div_divisor  = dsr_sel;
		end else begin
			div_dividend = DIV_NW'(pct_num);
			div_divisor  = capacity_q;
		end
	end

	tmfb_div #(
		.NW(DIV_NW),
		.DW(CAP_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= DEADBAND_RST;
			rot_thr_q    <= ROT_THR_RST;
			capacity_q   <= CAPACITY_RST;
			tick_scale_q <= TICK_SCALE_RST;
			empty_q      <= 1'b0;
			used_q       <= '0;
			rate_q       <= '0;
			for (int i = 0; i < NPUMP; i++) duty_q[i] <= '0;
			pump_q       <= '0;
			rate_acc_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_DEADBAND:   deadband_q   <= cfg_wdata[MAG_W-1:0];
					REG_ROT_THR:    rot_thr_q    <= cfg_wdata[MAG_W-1:0];
					REG_CAPACITY:   capacity_q   <= cfg_wdata[CAP_W-1:0];
					REG_TICK_SCALE: tick_scale_q <= cfg_wdata[SCALE_W-1:0];
					default: ;
				endcase
			end
			if (cmd_c.mix_load) begin
				pump_q     <= '0;
				rate_acc_q <= '0;
			end
			if (cmd_c.zero_write) begin
				duty_q[pump_q] <= '0;
				pump_q         <= pump_q + 2'd1;
			end
			if (cmd_c.duty_start)
				rate_acc_q <= (rate_sum > (NUM_W + 1)'(RATE_MAX)) ? RATE_MAX
					: rate_sum[RATE_W-1:0];
			if (cmd_c.duty_write) begin
				duty_q[pump_q] <= duty_new;
				pump_q         <= pump_q + 2'd1;
			end
			if (cmd_c.rate_write)
				rate_q <= rate_acc_q;
			if (cmd_c.tick_add) begin
				used_q <= used_new;
				// tank runs dry: stop all pumps
				if (used_new >= capacity_q) begin
					empty_q <= 1'b1;
					rate_q  <= '0;
					for (int i = 0; i < NPUMP; i++) duty_q[i] <= '0;
				end
			end
			if (cmd_c.refuel) begin
				empty_q <= 1'b0;
				used_q  <= '0;
			end
			if (cmd_c.out_load)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_c.capture) begin
			mode_q  <= in_mode;
			surge_q <= in_surge;
			sway_q  <= in_sway;
			yaw_q   <= in_yaw;
			flag_q  <= in_refuel_flag;
		end
		if (cmd_c.mix_load) begin
			for (int i = 0; i < NPUMP; i++) sum_q[i] <= sum_c[i];
			n_q <= n_c;
		end
		if (cmd_c.duty_start)
			x_q <= x;
		if (cmd_c.tick_mul)
			prod_q <= PROD_W'(tick_scale_q) * PROD_W'(rate_q);
		if (cmd_c.pct_zero)
			pct_q <= '0;
		else if (cmd_c.pct_write)
			pct_q <= quo[PCT_W-1:0];
		if (cmd_c.out_load) begin
			for (int i = 0; i < NPUMP; i++) out_duty_q[i] <= duty_q[i];
			out_pct_q   <= pct_q;
			out_empty_q <= empty_q;
		end
	end

	always_comb begin
		stat.mode        = mode_t'(mode_q);
		stat.empty       = empty_q;
		stat.refuel_flag = flag_q;
		stat.sum_zero    = cur_sum == '0;
		stat.last_pump   = pump_q == 2'd3;
		stat.div_done    = div_done;
		stat.pct_skip    = empty_q || (capacity_q == '0) || (used_q > capacity_q);
		stat.out_free    = !out_valid_q || res_ready;
	end

	assign res_valid = out_valid_q;
	assign duty_fl   = out_duty_q[0];
	assign duty_fr   = out_duty_q[1];
	assign duty_br   = out_duty_q[2];
	assign duty_bl   = out_duty_q[3];
	assign pct       = out_pct_q;
	assign empty     = out_empty_q;

endmodule

`default_nettype wire

FILE: rtl/tmfb_ctrl.sv
// Controller state machine: sequences capture, mixing, pump normalization,
// fuel ticks, refuel and the percentage divide. Uses tmfb_pkg.
`default_nettype none

module tmfb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  tmfb_pkg::dp_stat_t stat,
	output tmfb_pkg::dp_cmd_t  cmd_c
);

	import tmfb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_c     = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cmd_c.capture = 1'b1;
					state_d       = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.mode)
					MODE_THRUST: state_d = stat.empty ? ST_PCT : ST_MIX_SUM;
					MODE_TICK:   state_d = stat.empty ? ST_PCT : ST_TICK_MUL;
					MODE_REMOTE: begin
						cmd_c.refuel = stat.empty || stat.refuel_flag;
						state_d      = ST_PCT;
					end
					MODE_LOCAL: begin
						cmd_c.refuel = stat.empty;
						state_d      = ST_PCT;
					end
					default: state_d = ST_PCT;
				endcase
			end
			ST_MIX_SUM: begin
				cmd_c.mix_load = 1'b1;
				state_d        = ST_PUMP;
			end
			ST_PUMP: begin
				// idle pumps skip the divide and the duty multiply
				if (stat.sum_zero) begin
					cmd_c.zero_write = 1'b1;
					state_d          = stat.last_pump ? ST_MIX_END : ST_PUMP;
				end else begin
					cmd_c.num_start = 1'b1;
					state_d         = ST_NUM_DIV;
				end
			end
			ST_NUM_DIV: begin
				if (stat.div_done) begin
					cmd_c.duty_start = 1'b1;
					state_d          = ST_DUTY_DIV;
				end
			end
			ST_DUTY_DIV: begin
				cmd_c.duty_write = 1'b1;
				state_d          = stat.last_pump ? ST_MIX_END : ST_PUMP;
			end
			ST_MIX_END: begin
				cmd_c.rate_write = 1'b1;
				state_d          = ST_PCT;
			end
			ST_TICK_MUL: begin
				cmd_c.tick_mul = 1'b1;
				state_d        = ST_TICK_ADD;
			end
			ST_TICK_ADD: begin
				cmd_c.tick_add = 1'b1;
				state_d        = ST_PCT;
			end
			ST_PCT: begin
				if (stat.pct_skip) begin
					cmd_c.pct_zero = 1'b1;
					state_d        = ST_DONE;
				end else begin
					cmd_c.pct_start = 1'b1;
					state_d         = ST_PCT_DIV;
				end
			end
			ST_PCT_DIV: begin
				if (stat.div_done) begin
					cmd_c.pct_write = 1'b1;
					state_d         = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the result register is free
				if (stat.out_free) begin
					cmd_c.out_load = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/thrust_mixer_fuel_budget.sv
// Top level of the thrust mixer with fuel budget: controller and datapath.
// Uses tmfb_pkg, tmfb_if, tmfb_ctrl and tmfb_dp (which holds tmfb_div).
//
// channel  direction  handshake            word
// cmd      in         cmd.valid/cmd.ready  mode, surge, sway, yaw, refuel_flag
// res      out        res.valid/res.ready  four duties, fuel_percent, out_of_fuel
// cfg      in         cfg_we               cfg_idx, cfg_wdata (no read-back)
//
// One command word at a time. Pump normalization and the fuel percentage share one
// restoring divider of 40 quotient bits; the scale to duty is a reciprocal multiply.
// A zero percentage (empty tank, zero capacity, fuel past capacity) skips the
// percentage divide; a thrust or tick while empty goes straight to the percentage.
// The next word is taken as soon as the previous result sits in the output
// register; a stalled result holds and blocks the following word at its end.
// Reset clears all fuel state and duties and loads the register defaults.
`default_nettype none

module thrust_mixer_fuel_budget #(
	parameter int PWM_TOP = 999
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tmfb_cmd_if.sink                       cmd,
	tmfb_res_if.source                     res,
	input  logic                           cfg_we,
	input  logic [tmfb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tmfb_pkg::CFG_W-1:0]     cfg_wdata
);

	import tmfb_pkg::*;

	localparam int DUTY_W = $clog2(PWM_TOP + 1);

	dp_cmd_t           dcmd;
	dp_stat_t          dstat;
	logic [DUTY_W-1:0] duty_fl, duty_fr, duty_br, duty_bl;
	logic [PCT_W-1:0]  pct;
	logic              empty;
	logic              res_valid;

	tmfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.stat     (dstat),
		.cmd_c    (dcmd)
	);

	tmfb_dp #(
		.PWM_TOP(PWM_TOP),
		.DUTY_W (DUTY_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_c         (dcmd),
		.stat          (dstat),
		.in_mode       (cmd.mode),
		.in_surge      (cmd.surge),
		.in_sway       (cmd.sway),
		.in_yaw        (cmd.yaw),
		.in_refuel_flag(cmd.refuel_flag),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.res_ready     (res.ready),
		.res_valid     (res_valid),
		.duty_fl       (duty_fl),
		.duty_fr       (duty_fr),
		.duty_br       (duty_br),
		.duty_bl       (duty_bl),
		.pct           (pct),
		.empty         (empty)
	);

	assign res.valid            = res_valid;
	assign res.duty_front_left  = duty_fl;
	assign res.duty_front_right = duty_fr;
	assign res.duty_back_right  = duty_br;
	assign res.duty_back_left   = duty_bl;
	assign res.fuel_percent     = pct;
	assign res.out_of_fuel      = empty;

	a_empty_stops_pumps: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty |-> duty_fl == '0 && duty_fr == '0 && duty_br == '0
			&& duty_bl == '0 && pct == '0)
		else $error("pump running or fuel shown while out of fuel");

	a_duty_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> duty_fl <= DUTY_W'(PWM_TOP) && duty_fr <= DUTY_W'(PWM_TOP)
			&& duty_br <= DUTY_W'(PWM_TOP) && duty_bl <= DUTY_W'(PWM_TOP))
		else $error("duty above PWM period");

	a_one_divide: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dcmd.num_start, dcmd.pct_start}))
		else $error("divider started for two operations at once");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.out_load |-> !res_valid || res.ready)
		else $error("result register loaded over a waiting word");

endmodule

`default_nettype wire

FILE: verif/thrust_mixer_fuel_budget_tb.sv
// Self-checking bench for the thrust mixer with fuel budget: directed table, then random phases.
// A local fuel-budget predictor runs alongside the block, and results are compared field by field.
// Depends on tmfb_pkg, tmfb_if and thrust_mixer_fuel_budget.

module thrust_mixer_fuel_budget_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmfb_pkg::*;

	localparam int DUTY_TOP   = 999;
	localparam int RATE_TOP   = 4095;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 150;
	localparam int TAIL       = 400;
	localparam int LIMIT      = 6_000_000;
	localparam int FL = 0, FR = 1, BR = 2, BL = 3;

	typedef struct packed {
		logic [9:0] fl;
		logic [9:0] fr;
		logic [9:0] br;
		logic [9:0] bl;
		logic [7:0] pct;
		logic       oof;
	} status_t;

	typedef struct {
		logic        is_reg;
		reg_idx_t    idx;
		logic [31:0] val;
		mode_t       mode;
		int          surge;
		int          sway;
		int          yaw;
		logic        flag;
		logic        typed;
		status_t     want;
	} step_row_t;

	typedef struct {
		logic    typed;
		status_t want;
	} word_tag_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	tmfb_cmd_if cmd_ch();
	tmfb_res_if #(.DUTY_W(10)) res_ch();

	thrust_mixer_fuel_budget #(.PWM_TOP(DUTY_TOP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of registers and fuel state
	logic [6:0]  cfg_deadband = DEADBAND_RST;
	logic [6:0]  cfg_rot_thr  = ROT_THR_RST;
	logic [31:0] cfg_capacity = CAPACITY_RST;
	logic [9:0]  cfg_scale    = TICK_SCALE_RST;
	logic        fb_empty = 1'b0;
	logic [31:0] fb_used  = '0;
	logic [11:0] fb_rate  = '0;
	logic [9:0]  fb_duty [4] = '{default: '0};

	status_t   pending_status [$];
	word_tag_t word_tags [$];
	step_row_t steps [$];
	int        words_sent = 0;
	int        results_seen = 0;
	int        mismatches = 0;
	int        cycles = 0;
	logic      steady = 1'b0;
	logic      reg_open = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("thrust_mixer_fuel_budget regression: fail");
			$finish;
		end
	end

	function automatic int unsigned axis_mag(int v);
		if (v < -127)
			return 127;
		return (v < 0) ? -v : v;
	endfunction

	// Advance the fuel budget by one command word and return the status it reports.
	function automatic status_t next_status(mode_t m, logic signed [7:0] su,
		logic signed [7:0] sw, logic signed [7:0] yw, logic flag);
		longint unsigned acc [4];
		longint unsigned t, d, dv, rate, u, rem;
		int unsigned mag, k, n, share;
		status_t st;
		case (m)
		MODE_THRUST: begin
			if (!fb_empty) begin
				for (int i = 0; i < 4; i++)
					acc[i] = 0;
				k = 0;
				mag = axis_mag(su);
				if (mag > cfg_deadband) begin
					if (su < 0) begin
						acc[FL] += mag; acc[FR] += mag;
					end else begin
						acc[BR] += mag; acc[BL] += mag;
					end
					if (mag >= cfg_rot_thr)
						k++;
				end
				mag = axis_mag(sw);
				if (mag > cfg_deadband) begin
					if (sw < 0) begin
						acc[FL] += mag; acc[BL] += mag;
					end else begin
						acc[FR] += mag; acc[BR] += mag;
					end
					if (mag >= cfg_rot_thr)
						k++;
				end
				mag = axis_mag(yw);
				if (mag > cfg_deadband) begin
					// each strong translation axis takes a quarter off the yaw share
					share = (mag * (4 - k)) / 4;
					if (yw < 0) begin
						acc[FL] += share; acc[BR] += share;
					end else begin
						acc[FR] += share; acc[BL] += share;
					end
				end
				n = 0;
				for (int i = 0; i < 4; i++)
					if (acc[i] != 0)
						n++;
				rate = 0;
				for (int i = 0; i < 4; i++) begin
					if (acc[i] != 0) begin
						dv = (n >= 2) ? 127 * (n - 1) : 127;
						t = acc[i] * 3 * DUTY_TOP / dv / n;
						rate += t;
						d = (7 * t + 3 * DUTY_TOP) / 10;
						if (d > DUTY_TOP)
							d = DUTY_TOP;
						fb_duty[i] = d[9:0];
					end else begin
						fb_duty[i] = '0;
					end
				end
				fb_rate = (rate > RATE_TOP) ? 12'(RATE_TOP) : rate[11:0];
			end
		end
		MODE_TICK: begin
			if (!fb_empty) begin
				u = fb_used + cfg_scale * fb_rate;
				fb_used = (u > 64'hFFFF_FFFF) ? '1 : u[31:0];
				if (fb_used >= cfg_capacity) begin
					fb_empty = 1'b1;
					for (int i = 0; i < 4; i++)
						fb_duty[i] = '0;
					fb_rate = '0;
				end
			end
		end
		MODE_REMOTE: begin
			if (fb_empty || flag) begin
				fb_empty = 1'b0;
				fb_used = '0;
			end
		end
		default: begin
			if (fb_empty) begin
				fb_empty = 1'b0;
				fb_used = '0;
			end
		end
		endcase
		st.fl = fb_duty[FL];
		st.fr = fb_duty[FR];
		st.br = fb_duty[BR];
		st.bl = fb_duty[BL];
		if (fb_empty || cfg_capacity == 0 || fb_used > cfg_capacity) begin
			st.pct = '0;
		end else begin
			rem = cfg_capacity - fb_used;
			rem = rem * 255 / cfg_capacity;
			st.pct = rem[7:0];
		end
		st.oof = fb_empty;
		return st;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : watch_words
		status_t want;
		word_tag_t tag;
		status_t calc;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (pending_status.size() == 0) begin
					$error("result word with no expectation waiting");
					mismatches++;
				end else begin
					want = pending_status.pop_front();
					check_field("duty_front_left", want.fl, res_ch.duty_front_left);
					check_field("duty_front_right", want.fr, res_ch.duty_front_right);
					check_field("duty_back_right", want.br, res_ch.duty_back_right);
					check_field("duty_back_left", want.bl, res_ch.duty_back_left);
					check_field("fuel_percent", want.pct, res_ch.fuel_percent);
					check_field("out_of_fuel", want.oof, res_ch.out_of_fuel);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				tag = word_tags.pop_front();
				calc = next_status(mode_t'(cmd_ch.mode), cmd_ch.surge, cmd_ch.sway,
					cmd_ch.yaw, cmd_ch.refuel_flag);
				pending_status.push_back(tag.typed ? tag.want : calc);
			end
		end
	end

	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 30);
		return $urandom_range(100, 400);
	endfunction

	// result side: stall at random, counting from the moment a word is offered
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = gap_len();
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				do @(posedge clk); while (!res_ch.valid);
				repeat (stall - 1) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	task automatic send_word(mode_t m, int su, int sw, int yw, logic flag,
		logic typed, status_t want);
		int gap;
		word_tag_t tag;
		gap = gap_len();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tag.typed = typed;
		tag.want = want;
		word_tags.push_back(tag);
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= m;
		cmd_ch.surge <= 8'(su);
		cmd_ch.sway <= 8'(sw);
		cmd_ch.yaw <= 8'(yw);
		cmd_ch.refuel_flag <= flag;
		do @(posedge clk); while (!cmd_ch.ready);
		words_sent++;
	endtask

	// drop valid and hold until every word sent has come back
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (results_seen < words_sent)
			@(posedge clk);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
		REG_DEADBAND: cfg_deadband = val[6:0];
		REG_ROT_THR:  cfg_rot_thr = val[6:0];
		REG_CAPACITY: cfg_capacity = val;
		default:      cfg_scale = val[9:0];
		endcase
		@(posedge clk);
	endtask

	function automatic void add_reg(reg_idx_t idx, logic [31:0] val);
		step_row_t r;
		r.is_reg = 1'b1;
		r.idx = idx;
		r.val = val;
		r.mode = MODE_THRUST;
		r.surge = 0; r.sway = 0; r.yaw = 0;
		r.flag = 1'b0;
		r.typed = 1'b0;
		r.want = '0;
		steps.push_back(r);
	endfunction

	function automatic void add_word(mode_t m, int su, int sw, int yw, logic flag);
		step_row_t r;
		r.is_reg = 1'b0;
		r.idx = REG_DEADBAND;
		r.val = '0;
		r.mode = m;
		r.surge = su; r.sway = sw; r.yaw = yw;
		r.flag = flag;
		r.typed = 1'b0;
		r.want = '0;
		steps.push_back(r);
	endfunction

	function automatic void add_typed(mode_t m, int su, int sw, int yw, logic flag,
		int fl, int fr, int br, int bl, int pct, int oof);
		step_row_t r;
		r.is_reg = 1'b0;
		r.idx = REG_DEADBAND;
		r.val = '0;
		r.mode = m;
		r.surge = su; r.sway = sw; r.yaw = yw;
		r.flag = flag;
		r.typed = 1'b1;
		r.want.fl = 10'(fl);
		r.want.fr = 10'(fr);
		r.want.br = 10'(br);
		r.want.bl = 10'(bl);
		r.want.pct = 8'(pct);
		r.want.oof = oof[0];
		steps.push_back(r);
	endfunction

	function automatic int axis_value();
		int pick, a;
		pick = $urandom_range(0, 9);
		a = 0;
		case (pick)
		6: a = int'(cfg_deadband) + int'($urandom_range(0, 4)) - 2;
		7: a = int'(cfg_rot_thr) + int'($urandom_range(0, 4)) - 2;
		8: a = 127 + int'($urandom_range(0, 1));
		9: a = 0;
		default: return int'($urandom_range(0, 255)) - 128;
		endcase
		if (a < 0)
			a = 0;
		if (a > 127)
			return $urandom_range(0, 1) ? -128 : 127;
		return $urandom_range(0, 1) ? -a : a;
	endfunction

	task automatic random_word();
		int r;
		mode_t m;
		r = $urandom_range(0, 99);
		if (r < 50)
			m = MODE_THRUST;
		else if (r < 78)
			m = MODE_TICK;
		else if (r < 90)
			m = MODE_REMOTE;
		else
			m = MODE_LOCAL;
		send_word(m, axis_value(), axis_value(), axis_value(), 1'($urandom_range(0, 1)),
			1'b0, '0);
	endtask

	initial begin
		logic [31:0] db, rt, cap, sc;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_DEADBAND;
		cfg_wdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.mode <= MODE_THRUST;
		cmd_ch.surge <= '0;
		cmd_ch.sway <= '0;
		cmd_ch.yaw <= '0;
		cmd_ch.refuel_flag <= 1'b0;

		// defaults after reset: deadband 10, threshold 60
		add_typed(MODE_LOCAL, 0, 0, 0, 1'b0, 0, 0, 0, 0, 255, 0);
		add_typed(MODE_REMOTE, 0, 0, 0, 1'b0, 0, 0, 0, 0, 255, 0);
		add_typed(MODE_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 255, 0);
		add_typed(MODE_THRUST, 10, -10, 10, 1'b0, 0, 0, 0, 0, 255, 0);
		add_typed(MODE_THRUST, 127, 0, 0, 1'b0, 0, 0, 999, 999, 255, 0);
		add_typed(MODE_THRUST, -128, 0, 0, 1'b0, 999, 999, 0, 0, 255, 0);
		add_typed(MODE_THRUST, 0, 127, 0, 1'b0, 0, 999, 999, 0, 255, 0);
		add_typed(MODE_THRUST, 0, 0, -127, 1'b0, 999, 0, 999, 0, 255, 0);
		add_word(MODE_THRUST, 11, 0, 0, 1'b0);
		add_word(MODE_THRUST, 127, 127, 127, 1'b1);
		add_word(MODE_THRUST, 60, -60, 127, 1'b0);
		add_word(MODE_THRUST, 59, 59, -127, 1'b0);
		add_word(MODE_THRUST, -127, 127, -128, 1'b1);
		add_word(MODE_THRUST, 20, -30, 40, 1'b0);
		add_word(MODE_TICK, -1, -1, -1, 1'b1);
		add_word(MODE_REMOTE, 0, 0, 0, 1'b1);
		// a one-unit tank empties on the first tick that burns anything
		add_reg(REG_CAPACITY, 32'd1);
		add_typed(MODE_THRUST, 127, 0, 0, 1'b0, 0, 0, 999, 999, 255, 0);
		add_typed(MODE_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 1);
		add_typed(MODE_THRUST, 127, 127, 127, 1'b0, 0, 0, 0, 0, 0, 1);
		add_typed(MODE_TICK, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0, 1);
		add_typed(MODE_REMOTE, 0, 0, 0, 1'b0, 0, 0, 0, 0, 255, 0);
		add_typed(MODE_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 255, 0);
		add_reg(REG_CAPACITY, 32'd0);
		add_reg(REG_DEADBAND, 32'd0);
		add_reg(REG_ROT_THR, 32'd127);
		add_reg(REG_TICK_SCALE, 32'd1000);
		add_typed(MODE_LOCAL, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
		add_word(MODE_THRUST, 1, 0, 0, 1'b0);
		add_typed(MODE_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 1);
		add_typed(MODE_LOCAL, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_reg) begin
				if (!reg_open)
					settle();
				write_reg(steps[i].idx, steps[i].val);
				reg_open = 1'b1;
			end else begin
				if (reg_open)
					cfg_we <= 1'b0;
				reg_open = 1'b0;
				send_word(steps[i].mode, steps[i].surge, steps[i].sway, steps[i].yaw,
					steps[i].flag, steps[i].typed, steps[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 40);
			rt = $urandom_range(0, 127);
			cap = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 3_000_000);
			sc = $urandom_range(1, 1000);
			case (ph)
			0: begin db = 0; rt = 127; cap = CAPACITY_RST; sc = 1000; end
			1: begin db = 127; rt = 0; cap = 1; sc = 1; end
			2: cap = 0;
			3: begin cap = '1; sc = 1000; end
			default: ;
			endcase
			write_reg(REG_DEADBAND, db);
			write_reg(REG_ROT_THR, rt);
			write_reg(REG_CAPACITY, cap);
			write_reg(REG_TICK_SCALE, sc);
			cfg_we <= 1'b0;
			// every third phase runs back to back with no idling on either side
			steady = (ph % 3 == 2);
			repeat (PHASE_LEN) random_word();
		end

		settle();
		repeat (TAIL) @(posedge clk);
		if (pending_status.size() != 0)
			$error("%0d expected result words never arrived", pending_status.size());
		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("thrust_mixer_fuel_budget regression: pass");
		end else begin
			$display("thrust_mixer_fuel_budget regression: fail");
		end
		$finish;
	end

endmodule

FILE: thrust_mixer_fuel_budget.f
rtl/tmfb_pkg.sv
rtl/tmfb_if.sv
rtl/tmfb_div.sv
rtl/tmfb_dp.sv
rtl/tmfb_ctrl.sv
rtl/thrust_mixer_fuel_budget.sv
verif/thrust_mixer_fuel_budget_tb.sv
